[hdl/pwbd_pkg.sv]
package pwbd_pkg;

  typedef enum logic [1:0] {
    PH_WAIT_HIGH,
    PH_WAIT_FALL,
    PH_LOW,
    PH_HIGH
  } phase_t;

  localparam int unsigned SYM_W = 2;

  localparam logic [SYM_W-1:0] SYM_ZERO      = 2'd0;
  localparam logic [SYM_W-1:0] SYM_ONE       = 2'd1;
  localparam logic [SYM_W-1:0] SYM_CTRL_STOP = 2'd2;
  localparam logic [SYM_W-1:0] SYM_CONS_STOP = 2'd3;

  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_W     = 16;

  localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW_MIN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_NOMINAL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW_MAX = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MID_LOW_MIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MID_LOW_MAX   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LONG_LOW_MIN  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LONG_NOMINAL  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LONG_LOW_MAX  = 3'd7;

  localparam logic [REG_W-1:0] REG_RESET [REG_COUNT] = '{
    16'd75, 16'd100, 16'd125, 16'd175, 16'd225, 16'd275, 16'd300, 16'd325
  };

  // width of every position field on the result port
  localparam int unsigned OUT_POS_W = 48;

  // internal handshake between pipeline stages
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_hs_t;

endpackage

[hdl/pulse_width_bit_decoder_unit.sv]
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata[0] line_level
// m_*       out  tvalid/tready      tdata start/end/mid, tuser symbol/is_data_bit
// cfg_*     in   cfg_we (no wait)   cfg_index selects register, cfg_data value
//
// One sample per cycle while s_tready is high; after the sample ending a symbol is
// accepted it passes the tracker, classify and midpoint registers before m_tvalid rises.
// rst is synchronous: decoder waits for line high, sample index 0, config regs
// back to defaults, pipeline empty.
// s_tready drops only when every stage is full and m_tready is low.
module pulse_width_bit_decoder_unit
  import pwbd_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 48,
  parameter int unsigned DURATION_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [0] line_level, [7:1] zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [143:0]         m_tdata,   // [47:0] start_pos, [95:48] end_pos,
                                          // [143:96] mid_pos
  output logic [2:0]           m_tuser,   // [1:0] symbol, [2] is_data_bit
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  stage_hs_t                 ev_hs;
  logic                      ev_ready;
  logic [POSITION_WIDTH-1:0] ev_start, ev_rise, ev_now, ev_d_now, ev_d_rise;
  logic [DURATION_WIDTH-1:0] ev_low_dur, ev_high_dur;
  logic                      sym_valid, sym_ready;
  logic [SYM_W-1:0]          sym_code;
  logic [POSITION_WIDTH-1:0] sym_start, sym_end, sym_diff;
  logic [SYM_W-1:0]          out_symbol;
  logic [OUT_POS_W-1:0]      out_start, out_end, out_mid;
  logic                      out_is_data;

  pwbd_tracker #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .DURATION_WIDTH(DURATION_WIDTH)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .line_level  (s_tdata[0]),
    .ev_hs_out   (ev_hs),
    .ev_ready    (ev_ready),
    .ev_start    (ev_start),
    .ev_rise     (ev_rise),
    .ev_now      (ev_now),
    .ev_d_now    (ev_d_now),
    .ev_d_rise   (ev_d_rise),
    .ev_low_dur  (ev_low_dur),
    .ev_high_dur (ev_high_dur)
  );

  pwbd_classify #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .DURATION_WIDTH(DURATION_WIDTH)
  ) u_classify (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ev_hs_in    (ev_hs),
    .ev_ready    (ev_ready),
    .ev_start    (ev_start),
    .ev_rise     (ev_rise),
    .ev_now      (ev_now),
    .ev_d_now    (ev_d_now),
    .ev_d_rise   (ev_d_rise),
    .ev_low_dur  (ev_low_dur),
    .ev_high_dur (ev_high_dur),
    .sym_valid   (sym_valid),
    .sym_ready   (sym_ready),
    .sym_code    (sym_code),
    .sym_start   (sym_start),
    .sym_end     (sym_end),
    .sym_diff    (sym_diff)
  );

  pwbd_midpoint #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_midpoint (
    .clk         (clk),
    .rst         (rst),
    .sym_valid   (sym_valid),
    .sym_ready   (sym_ready),
    .sym_code    (sym_code),
    .sym_start   (sym_start),
    .sym_end     (sym_end),
    .sym_diff    (sym_diff),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_symbol  (out_symbol),
    .out_start   (out_start),
    .out_end     (out_end),
    .out_mid     (out_mid),
    .out_is_data (out_is_data)
  );

  assign m_tdata = {out_mid, out_end, out_start};
  assign m_tuser = {out_is_data, out_symbol};

`ifndef SYNTH
  a_data_flag : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[2] == (m_tuser[1] == 1'b0)))
    else $error("is_data_bit does not match symbol");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output side free");

  a_reset_empty : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

[hdl/pwbd_tracker.sv]
module pwbd_tracker
  import pwbd_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 48,
  parameter int unsigned DURATION_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      line_level,
  output stage_hs_t                 ev_hs_out,
  input  logic                      ev_ready,
  output logic [POSITION_WIDTH-1:0] ev_start,
  output logic [POSITION_WIDTH-1:0] ev_rise,
  output logic [POSITION_WIDTH-1:0] ev_now,
  output logic [POSITION_WIDTH-1:0] ev_d_now,
  output logic [POSITION_WIDTH-1:0] ev_d_rise,
  output logic [DURATION_WIDTH-1:0] ev_low_dur,
  output logic [DURATION_WIDTH-1:0] ev_high_dur
);

  phase_t                    phase;
  phase_t                    phase_next;
  logic [POSITION_WIDTH-1:0] sample_index;
  logic [POSITION_WIDTH-1:0] low_start_pos;
  logic [POSITION_WIDTH-1:0] low_end_pos;
  logic [DURATION_WIDTH-1:0] low_dur;
  logic                      ev_valid;
  logic                      accept;
  logic                      fall_event;
  logic                      rise_event;
  logic                      start_event;
  logic [POSITION_WIDTH-1:0] low_span;
  logic [POSITION_WIDTH-1:0] high_span;
  logic [DURATION_WIDTH-1:0] low_sat;
  logic [DURATION_WIDTH-1:0] high_sat;

  assign in_ready = !ev_valid || ev_ready;
  assign accept   = in_valid && in_ready;

  assign low_span  = sample_index - low_start_pos;
  assign high_span = sample_index - low_end_pos;

  generate
    if (POSITION_WIDTH > DURATION_WIDTH) begin : g_sat
      assign low_sat  = (|low_span[POSITION_WIDTH-1:DURATION_WIDTH]) ? '1
                        : low_span[DURATION_WIDTH-1:0];
      assign high_sat = (|high_span[POSITION_WIDTH-1:DURATION_WIDTH]) ? '1
                        : high_span[DURATION_WIDTH-1:0];
    end else begin : g_nosat
      assign low_sat  = DURATION_WIDTH'(low_span);
      assign high_sat = DURATION_WIDTH'(high_span);
    end
  endgenerate

  always_comb begin
    phase_next  = phase;
    start_event = 1'b0;
    rise_event  = 1'b0;
    fall_event  = 1'b0;
    case (phase)
      PH_WAIT_HIGH: begin
        if (line_level) phase_next = PH_WAIT_FALL;
      end
      PH_WAIT_FALL: begin
        if (!line_level) begin
          start_event = 1'b1;
          phase_next  = PH_LOW;
        end
      end
      PH_LOW: begin
        if (line_level) begin
          rise_event = 1'b1;
          phase_next = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (!line_level) begin
          fall_event = 1'b1;
          phase_next = PH_LOW;
        end
      end
      default: phase_next = PH_WAIT_HIGH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_HIGH;
      sample_index <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      sample_index <= sample_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (start_event || fall_event)) low_start_pos <= sample_index;
    if (accept && rise_event) begin
      low_end_pos <= sample_index;
      low_dur     <= low_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (accept && fall_event) begin
      ev_valid <= 1'b1;
    end else if (ev_ready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fall_event) begin
      ev_start    <= low_start_pos;
      ev_rise     <= low_end_pos;
      ev_now      <= sample_index;
      ev_d_now    <= low_span;
      ev_d_rise   <= low_end_pos - low_start_pos;
      ev_low_dur  <= low_dur;
      ev_high_dur <= high_sat;
    end
  end

  assign ev_hs_out.valid = ev_valid;
  assign ev_hs_out.ready = in_ready;

endmodule

[hdl/pwbd_classify.sv]
module pwbd_classify
  import pwbd_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 48,
  parameter int unsigned DURATION_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [REG_IDX_W-1:0]      cfg_index,
  input  logic [REG_W-1:0]          cfg_data,
  input  stage_hs_t                 ev_hs_in,
  output logic                      ev_ready,
  input  logic [POSITION_WIDTH-1:0] ev_start,
  input  logic [POSITION_WIDTH-1:0] ev_rise,
  input  logic [POSITION_WIDTH-1:0] ev_now,
  input  logic [POSITION_WIDTH-1:0] ev_d_now,
  input  logic [POSITION_WIDTH-1:0] ev_d_rise,
  input  logic [DURATION_WIDTH-1:0] ev_low_dur,
  input  logic [DURATION_WIDTH-1:0] ev_high_dur,
  output logic                      sym_valid,
  input  logic                      sym_ready,
  output logic [SYM_W-1:0]          sym_code,
  output logic [POSITION_WIDTH-1:0] sym_start,
  output logic [POSITION_WIDTH-1:0] sym_end,
  output logic [POSITION_WIDTH-1:0] sym_diff
);

  localparam int unsigned CMP_W = (DURATION_WIDTH > REG_W) ? DURATION_WIDTH : REG_W;

  logic [REG_W-1:0]          cfg_regs [REG_COUNT];
  logic [CMP_W-1:0]          lo_d;
  logic [CMP_W-1:0]          hi_d;
  logic [CMP_W-1:0]          r_smin, r_smax, r_mmin, r_mmax, r_lmin, r_lmax;
  logic                      short_hit, mid_hit, long_hit;
  logic                      emit;
  logic [SYM_W-1:0]          code;
  logic                      use_now;
  logic                      use_clamp;
  logic [POSITION_WIDTH-1:0] nominal;
  logic [POSITION_WIDTH-1:0] end_pos;
  logic [POSITION_WIDTH-1:0] diff;
  logic                      take;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) cfg_regs[i] <= REG_RESET[i];
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  assign lo_d   = CMP_W'(ev_low_dur);
  assign hi_d   = CMP_W'(ev_high_dur);
  assign r_smin = CMP_W'(cfg_regs[REG_SHORT_LOW_MIN]);
  assign r_smax = CMP_W'(cfg_regs[REG_SHORT_LOW_MAX]);
  assign r_mmin = CMP_W'(cfg_regs[REG_MID_LOW_MIN]);
  assign r_mmax = CMP_W'(cfg_regs[REG_MID_LOW_MAX]);
  assign r_lmin = CMP_W'(cfg_regs[REG_LONG_LOW_MIN]);
  assign r_lmax = CMP_W'(cfg_regs[REG_LONG_LOW_MAX]);

  assign short_hit = (lo_d >= r_smin) && (lo_d <= r_smax);
  assign mid_hit   = (lo_d >= r_mmin) && (lo_d <= r_mmax);
  assign long_hit  = (lo_d >= r_lmin) && (lo_d <= r_lmax);

  // priority: short window, controller stop, long window
  always_comb begin
    emit      = 1'b0;
    code      = SYM_ZERO;
    use_now   = 1'b0;
    use_clamp = 1'b0;
    nominal   = POSITION_WIDTH'(cfg_regs[REG_SHORT_NOMINAL]);
    if (short_hit) begin
      emit = 1'b1;
      if (hi_d >= r_lmin) begin
        code      = SYM_ONE;
        nominal   = POSITION_WIDTH'(cfg_regs[REG_LONG_NOMINAL]);
        use_clamp = hi_d > r_lmax;
        use_now   = !use_clamp;
      end else begin
        code = SYM_CONS_STOP;
      end
    end else if (mid_hit) begin
      emit = 1'b1;
      code = SYM_CTRL_STOP;
    end else if (long_hit && (hi_d >= r_smin)) begin
      emit      = 1'b1;
      code      = SYM_ZERO;
      use_clamp = hi_d > r_smax;
      use_now   = !use_clamp;
    end
  end

  always_comb begin
    if (use_now) begin
      end_pos = ev_now;
      diff    = ev_d_now;
    end else if (use_clamp) begin
      end_pos = ev_rise + nominal;
      diff    = ev_d_rise + nominal;
    end else begin
      end_pos = ev_rise;
      diff    = ev_d_rise;
    end
  end

  assign ev_ready = !sym_valid || sym_ready;
  assign take     = ev_hs_in.valid && ev_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (take) begin
      sym_valid <= emit;
    end else if (sym_ready) begin
      sym_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sym_code  <= code;
      sym_start <= ev_start;
      sym_end   <= end_pos;
      sym_diff  <= diff;
    end
  end

endmodule

[hdl/pwbd_midpoint.sv]
module pwbd_midpoint
  import pwbd_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sym_valid,
  output logic                      sym_ready,
  input  logic [SYM_W-1:0]          sym_code,
  input  logic [POSITION_WIDTH-1:0] sym_start,
  input  logic [POSITION_WIDTH-1:0] sym_end,
  input  logic [POSITION_WIDTH-1:0] sym_diff,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SYM_W-1:0]          out_symbol,
  output logic [OUT_POS_W-1:0]      out_start,
  output logic [OUT_POS_W-1:0]      out_end,
  output logic [OUT_POS_W-1:0]      out_mid,
  output logic                      out_is_data
);

  logic [POSITION_WIDTH-1:0] mid;
  logic                      take;

  assign mid       = sym_start + (sym_diff >> 1);
  assign sym_ready = !out_valid || out_ready;
  assign take      = sym_valid && sym_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_symbol  <= sym_code;
      out_start   <= OUT_POS_W'(sym_start);
      out_end     <= OUT_POS_W'(sym_end);
      out_mid     <= OUT_POS_W'(mid);
      out_is_data <= (sym_code == SYM_ZERO) || (sym_code == SYM_ONE);
    end
  end

endmodule

[verif/pulse_width_bit_decoder_unit_tb.sv]
module pulse_width_bit_decoder_unit_tb;
  import pwbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef logic [REG_W-1:0] reg_bank_t [REG_COUNT];

  typedef struct packed {
    logic [SYM_W-1:0]     symbol;
    logic [OUT_POS_W-1:0] start_pos;
    logic [OUT_POS_W-1:0] end_pos;
    logic [OUT_POS_W-1:0] mid_pos;
    logic                 is_data_bit;
  } pulse_symbol_t;

  class symbol_predictor;
    phase_t               line_phase;
    logic [OUT_POS_W-1:0] sample_idx;
    logic [OUT_POS_W-1:0] fall_pos;
    logic [OUT_POS_W-1:0] rise_pos;
    logic [REG_W-1:0]     bounds [REG_COUNT];
    pulse_symbol_t        expected_symbols [$];
    int                   errors;

    function new();
      line_phase = PH_WAIT_HIGH;
      sample_idx = '0;
      fall_pos = '0;
      rise_pos = '0;
      for (int i = 0; i < REG_COUNT; i++) bounds[i] = REG_RESET[i];
      errors = 0;
    endfunction

    function void set_bound(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      bounds[idx] = val;
    endfunction

    // edge distance, saturated to the duration width
    function logic [REG_W-1:0] duration(input logic [OUT_POS_W-1:0] from_pos,
                                        input logic [OUT_POS_W-1:0] to_pos);
      logic [OUT_POS_W-1:0] d;
      d = to_pos - from_pos;
      if (d[OUT_POS_W-1:REG_W] != '0) return '1;
      return d[REG_W-1:0];
    endfunction

    function void push_symbol(input logic [SYM_W-1:0] sym, input logic [OUT_POS_W-1:0] end_at);
      pulse_symbol_t s;
      s.symbol = sym;
      s.start_pos = fall_pos;
      s.end_pos = end_at;
      s.mid_pos = fall_pos + ((end_at - fall_pos) >> 1);
      s.is_data_bit = (sym == SYM_ZERO) || (sym == SYM_ONE);
      expected_symbols.push_back(s);
    endfunction

    function void take_sample(input logic level);
      logic [REG_W-1:0]     low_d;
      logic [REG_W-1:0]     high_d;
      logic [OUT_POS_W-1:0] end_at;
      case (line_phase)
        PH_WAIT_HIGH: if (level) line_phase = PH_WAIT_FALL;
        PH_WAIT_FALL: if (!level) begin
          fall_pos = sample_idx;
          line_phase = PH_LOW;
        end
        PH_LOW: if (level) begin
          rise_pos = sample_idx;
          line_phase = PH_HIGH;
        end
        default: if (!level) begin
          low_d = duration(fall_pos, rise_pos);
          high_d = duration(rise_pos, sample_idx);
          end_at = sample_idx;
          if (low_d >= bounds[REG_SHORT_LOW_MIN] && low_d <= bounds[REG_SHORT_LOW_MAX]) begin
            if (high_d >= bounds[REG_LONG_LOW_MIN]) begin
              if (high_d > bounds[REG_LONG_LOW_MAX]) end_at = rise_pos + bounds[REG_LONG_NOMINAL];
              push_symbol(SYM_ONE, end_at);
            end else begin
              push_symbol(SYM_CONS_STOP, rise_pos);
            end
          end else if (low_d >= bounds[REG_MID_LOW_MIN] && low_d <= bounds[REG_MID_LOW_MAX]) begin
            push_symbol(SYM_CTRL_STOP, rise_pos);
          end else if (low_d >= bounds[REG_LONG_LOW_MIN] && low_d <= bounds[REG_LONG_LOW_MAX]
                       && high_d >= bounds[REG_SHORT_LOW_MIN]) begin
            if (high_d > bounds[REG_SHORT_LOW_MAX]) end_at = rise_pos + bounds[REG_SHORT_NOMINAL];
            push_symbol(SYM_ZERO, end_at);
          end
          fall_pos = sample_idx;
          line_phase = PH_LOW;
        end
      endcase
      sample_idx = sample_idx + 1'b1;
    endfunction

    function void compare_field(input string name, input logic [OUT_POS_W-1:0] want_v,
                                input logic [OUT_POS_W-1:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_symbol(input logic [143:0] data, input logic [2:0] user);
      pulse_symbol_t want;
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected symbol, expected none, actual symbol %0d start %0d",
                 $time, user[SYM_W-1:0], data[47:0]);
        errors++;
        return;
      end
      want = expected_symbols.pop_front();
      compare_field("symbol", OUT_POS_W'(want.symbol), OUT_POS_W'(user[SYM_W-1:0]));
      compare_field("is_data_bit", OUT_POS_W'(want.is_data_bit), OUT_POS_W'(user[2]));
      compare_field("start_pos", want.start_pos, data[47:0]);
      compare_field("end_pos", want.end_pos, data[95:48]);
      compare_field("mid_pos", want.mid_pos, data[143:96]);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [143:0]         m_tdata;
  logic [2:0]           m_tuser;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  bit                   idle_on = 1'b1;
  int unsigned          sent = 0;
  int unsigned          cycles = 0;
  reg_bank_t            cfg_now;
  symbol_predictor      predictor = new();

  pulse_width_bit_decoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pulse_width_bit_decoder_unit_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) predictor.check_symbol(m_tdata, m_tuser);
      if (s_tvalid && s_tready) predictor.take_sample(s_tdata[0]);
    end
  end

  // receiver stalls
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_sample(input logic level);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, level};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_run(input logic level, input int unsigned len);
    repeat (len) send_sample(level);
  endtask

  task automatic send_pulse(input int unsigned low_len, input int unsigned high_len);
    send_run(1'b0, low_len);
    send_run(1'b1, high_len);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predictor.expected_symbols.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_config(input reg_bank_t vals);
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      predictor.set_bound(REG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    cfg_now = vals;
  endtask

  function automatic void make_bank(output reg_bank_t b,
                                    input int unsigned smin, input int unsigned snom,
                                    input int unsigned smax, input int unsigned mmin,
                                    input int unsigned mmax, input int unsigned lmin,
                                    input int unsigned lnom, input int unsigned lmax);
    b[REG_SHORT_LOW_MIN] = REG_W'(smin);
    b[REG_SHORT_NOMINAL] = REG_W'(snom);
    b[REG_SHORT_LOW_MAX] = REG_W'(smax);
    b[REG_MID_LOW_MIN]   = REG_W'(mmin);
    b[REG_MID_LOW_MAX]   = REG_W'(mmax);
    b[REG_LONG_LOW_MIN]  = REG_W'(lmin);
    b[REG_LONG_NOMINAL]  = REG_W'(lnom);
    b[REG_LONG_LOW_MAX]  = REG_W'(lmax);
  endfunction

  // mostly ordered windows with small sizes, sometimes overlapping or crossed
  function automatic void random_bank(output reg_bank_t b);
    int unsigned mark;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < REG_COUNT; i++) b[i] = REG_W'($urandom_range(0, 20));
      return;
    end
    mark = $urandom_range(1, 4);
    b[REG_SHORT_LOW_MIN] = REG_W'(mark);
    mark += $urandom_range(0, 3);
    b[REG_SHORT_LOW_MAX] = REG_W'(mark);
    mark += $urandom_range(1, 3);
    b[REG_MID_LOW_MIN] = REG_W'(mark);
    mark += $urandom_range(0, 3);
    b[REG_MID_LOW_MAX] = REG_W'(mark);
    mark += $urandom_range(1, 3);
    b[REG_LONG_LOW_MIN] = REG_W'(mark);
    mark += $urandom_range(0, 3);
    b[REG_LONG_LOW_MAX] = REG_W'(mark);
    b[REG_SHORT_NOMINAL] = REG_W'($urandom_range(1, 20));
    b[REG_LONG_NOMINAL] = REG_W'($urandom_range(1, 40));
  endfunction

  // length biased to the window bounds and just outside them
  function automatic int unsigned near_window(input logic [REG_W-1:0] lo,
                                              input logic [REG_W-1:0] hi);
    int unsigned lo_v;
    int unsigned hi_v;
    int unsigned v;
    lo_v = 32'(lo);
    hi_v = 32'(hi);
    case ($urandom_range(0, 5))
      0: v = (lo_v > 1) ? lo_v - 1 : 1;
      1: v = lo_v;
      2: v = hi_v;
      3: v = hi_v + 1;
      default: v = $urandom_range(lo_v, hi_v);
    endcase
    return (v == 0) ? 1 : v;
  endfunction

  task automatic random_pulse();
    int unsigned low_len;
    int unsigned high_len;
    case ($urandom_range(0, 9))
      0, 1, 2: low_len = near_window(cfg_now[REG_SHORT_LOW_MIN], cfg_now[REG_SHORT_LOW_MAX]);
      3, 4:    low_len = near_window(cfg_now[REG_MID_LOW_MIN], cfg_now[REG_MID_LOW_MAX]);
      5, 6, 7: low_len = near_window(cfg_now[REG_LONG_LOW_MIN], cfg_now[REG_LONG_LOW_MAX]);
      default: low_len = $urandom_range(1, cfg_now[REG_LONG_LOW_MAX] + 4);
    endcase
    case ($urandom_range(0, 4))
      0, 1:    high_len = near_window(cfg_now[REG_LONG_LOW_MIN], cfg_now[REG_LONG_LOW_MAX]);
      2, 3:    high_len = near_window(cfg_now[REG_SHORT_LOW_MIN], cfg_now[REG_SHORT_LOW_MAX]);
      default: high_len = $urandom_range(1, cfg_now[REG_LONG_LOW_MAX] + 4);
    endcase
    send_pulse(low_len, high_len);
  endtask

  initial begin
    reg_bank_t   bank;
    int unsigned random_base;
    int unsigned phase_start;
    cfg_now = REG_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset windows; line low first, ignored until it goes high
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_pulse(80, 20);   // console stop
    send_pulse(180, 5);   // controller stop
    send_run(1'b0, 1);
    settle();

    make_bank(bank, 3, 5, 4, 6, 7, 9, 11, 10);
    load_config(bank);
    send_pulse(3, 9);    // one bit, high at window min
    send_pulse(4, 10);   // one bit, high at window max
    send_pulse(3, 11);   // one bit, end clamped
    send_pulse(4, 8);    // console stop
    send_pulse(6, 2);    // controller stop
    send_pulse(7, 1);
    send_pulse(9, 3);    // zero bit
    send_pulse(10, 4);
    send_pulse(9, 5);    // zero bit, end clamped
    send_pulse(10, 2);   // zero bit with short high: dropped
    send_pulse(2, 5);    // lows between and outside windows: dropped
    send_pulse(5, 5);
    send_pulse(8, 5);
    send_pulse(11, 5);
    send_run(1'b0, 1);
    settle();

    // crossed mid window, largest nominal clamp
    make_bank(bank, 3, 65535, 4, 1, 0, 9, 65535, 10);
    load_config(bank);
    send_pulse(3, 11);
    send_pulse(9, 5);
    send_pulse(1, 5);
    send_run(1'b0, 1);
    settle();

    make_bank(bank, 0, 0, 0, 0, 0, 0, 0, 0);
    load_config(bank);
    repeat (10) random_pulse();
    send_run(1'b0, 1);
    settle();

    random_base = sent;
    while (sent - random_base < 300) begin
      random_bank(bank);
      load_config(bank);
      phase_start = sent;
      while (sent - phase_start < 100) random_pulse();
      settle();
    end

    idle_on = 1'b0;
    random_bank(bank);
    load_config(bank);
    phase_start = sent;
    while (sent - phase_start < 100) random_pulse();
    send_run(1'b0, 1);
    settle();

    if (predictor.errors == 0) $display("pulse_width_bit_decoder_unit_tb OK");
    else $display("pulse_width_bit_decoder_unit_tb NOT OK");
    $finish;
  end

endmodule

[pulse_width_bit_decoder_unit.f]
hdl/pwbd_pkg.sv
hdl/pwbd_tracker.sv
hdl/pwbd_classify.sv
hdl/pwbd_midpoint.sv
hdl/pulse_width_bit_decoder_unit.sv
verif/pulse_width_bit_decoder_unit_tb.sv
